// ===== design/msa_pkg.sv =====
// package for the midi sysex assembler
// holds byte codes, output kind codes, register indexes and controller/datapath structs
// no dependencies
package msa_pkg;

    localparam int DEF_SYSEX_DEPTH = 32;

    localparam logic [7:0] SYSEX_START = 8'hF0;
    localparam logic [7:0] SYSEX_END   = 8'hF7;
    localparam logic [7:0] RT_CLOCK    = 8'hF8;
    localparam logic [7:0] RT_START    = 8'hFA;
    localparam logic [7:0] RT_CONTINUE = 8'hFB;
    localparam logic [7:0] RT_STOP     = 8'hFC;
    localparam logic [7:0] RT_SENSE    = 8'hFE;
    localparam logic [7:0] RT_RESET    = 8'hFF;
    localparam logic [7:0] STATUS_MASK = 8'h80;

    localparam logic [6:0] MAKER_FIRST_RST  = 7'h43;
    localparam logic [6:0] MAKER_SECOND_RST = 7'h7D;

    localparam logic REG_MAKER_FIRST  = 1'b0;
    localparam logic REG_MAKER_SECOND = 1'b1;

    localparam logic [1:0] KIND_PLAIN = 2'd0;
    localparam logic [1:0] KIND_RT    = 2'd1;
    localparam logic [1:0] KIND_SYSEX = 2'd2;

    typedef struct packed {
        logic load;
        logic step;
        logic rd;
        logic dump_emit;
    } msa_cmd_t;

    typedef struct packed {
        logic len_zero;
        logic emit_req;
        logic end_pkt;
        logic start_dump;
        logic dump_last;
        logic out_free;
    } msa_stat_t;

    function automatic logic is_realtime(input logic [7:0] x);
        return (x == RT_CLOCK) || (x == RT_START) || (x == RT_CONTINUE) ||
               (x == RT_STOP) || (x == RT_SENSE) || (x == RT_RESET);
    endfunction

endpackage

// ===== design/msa_if.sv =====
// valid/ready channel interfaces for the midi sysex assembler
// msa_pkt_if carries input packets, msa_byte_if carries delivered bytes
// no dependencies
interface msa_pkt_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_zero;
    logic [7:0] byte_one;
    logic [7:0] byte_two;
    logic [1:0] length;
    logic [3:0] cable;

    modport source (output valid, byte_zero, byte_one, byte_two, length, cable, input ready);
    modport sink   (input valid, byte_zero, byte_one, byte_two, length, cable, output ready);
endinterface

interface msa_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic [3:0] out_cable;
    logic [1:0] kind;
    logic       last;

    modport source (output valid, data_byte, out_cable, kind, last, input ready);
    modport sink   (input valid, data_byte, out_cable, kind, last, output ready);
endinterface

// ===== design/msa_datapath.sv =====
// datapath of the midi sysex assembler: packet register, message store,
// fill count, manufacturer ids and output register
// depends on msa_pkg
module msa_datapath #(
    parameter int SYSEX_DEPTH = msa_pkg::DEF_SYSEX_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  msa_pkg::msa_cmd_t  cmd,
    output msa_pkg::msa_stat_t stat,
    input  logic [7:0]         byte_zero,
    input  logic [7:0]         byte_one,
    input  logic [7:0]         byte_two,
    input  logic [1:0]         length,
    input  logic [3:0]         cable,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [6:0]         cfg_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         data_byte,
    output logic [3:0]         out_cable,
    output logic [1:0]         kind,
    output logic               last
);
    import msa_pkg::*;

    localparam int FW = $clog2(SYSEX_DEPTH + 1);
    localparam int AW = $clog2(SYSEX_DEPTH);

    localparam logic [1:0] MODE_PASS  = 2'd0;
    localparam logic [1:0] MODE_OPEN  = 2'd1;
    localparam logic [1:0] MODE_SYSEX = 2'd2;

    logic [7:0]    mem [SYSEX_DEPTH];
    logic [7:0]    rd_data_reg;

    logic [7:0]    b0_reg, b1_reg, b2_reg;
    logic [1:0]    len_reg;
    logic [3:0]    cable_reg;
    logic [1:0]    mode_reg;
    logic [1:0]    idx_reg;
    logic [FW-1:0] fill_reg, fill_next;
    logic [7:0]    maker_byte_reg;
    logic [FW-1:0] dump_len_reg;
    logic [FW-1:0] rd_ptr_reg;
    logic [6:0]    id_first_reg, id_second_reg;

    logic          out_valid_reg;
    logic [7:0]    out_byte_reg;
    logic [3:0]    out_cable_reg;
    logic [1:0]    out_kind_reg;
    logic          out_last_reg;

    logic [7:0]    cur;
    logic          is_last_byte;
    logic [7:0]    mk;
    logic          maker_match;
    logic          fill_full;
    logic          wr_en;
    logic          emit_req;
    logic          terminate;
    logic          start_dump;
    logic [1:0]    emit_kind;
    logic          emit_last;
    logic          out_load;

    always_comb
    begin
        case (idx_reg)
            2'd0:    cur = b0_reg;
            2'd1:    cur = b1_reg;
            default: cur = b2_reg;
        endcase
    end

    assign is_last_byte = (idx_reg == (len_reg - 2'd1));
    // the byte at store index one is the manufacturer byte, possibly written right now
    assign mk           = (fill_reg == FW'(1)) ? cur : maker_byte_reg;
    assign maker_match  = (mk == {1'b0, id_first_reg}) || (mk == {1'b0, id_second_reg});
    assign fill_full    = (fill_reg >= FW'(SYSEX_DEPTH));

    always_comb
    begin
        wr_en      = 1'b0;
        emit_req   = 1'b0;
        terminate  = 1'b0;
        start_dump = 1'b0;
        emit_kind  = KIND_PLAIN;
        emit_last  = is_last_byte;
        fill_next  = fill_reg;
        case (mode_reg)
            MODE_OPEN:
            begin
                wr_en     = 1'b1;
                fill_next = fill_reg + FW'(1);
                // early manufacturer check once three bytes are stored
                if (idx_reg == 2'd2 && !maker_match)
                    fill_next = '0;
            end
            MODE_PASS:
            begin
                emit_req = 1'b1;
            end
            MODE_SYSEX:
            begin
                if (is_realtime(cur))
                begin
                    emit_req  = 1'b1;
                    emit_kind = KIND_RT;
                    emit_last = 1'b1;
                end
                else if (fill_full)
                begin
                    fill_next = '0;
                    terminate = 1'b1;
                end
                else if (cur == SYSEX_END)
                begin
                    wr_en      = 1'b1;
                    start_dump = maker_match;
                    fill_next  = '0;
                    terminate  = 1'b1;
                end
                else if ((cur & STATUS_MASK) != 8'h00)
                begin
                    fill_next = '0;
                    terminate = 1'b1;
                end
                else
                begin
                    wr_en     = 1'b1;
                    fill_next = fill_reg + FW'(1);
                    if (fill_reg == FW'(1) && !maker_match)
                    begin
                        fill_next = '0;
                        terminate = 1'b1;
                    end
                end
            end
            default:
            begin
                terminate = 1'b1;
            end
        endcase
    end

    assign stat.len_zero   = (length == 2'd0);
    assign stat.emit_req   = emit_req;
    assign stat.end_pkt    = terminate || is_last_byte;
    assign stat.start_dump = start_dump;
    assign stat.dump_last  = (rd_ptr_reg == (dump_len_reg - FW'(1)));
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign out_load = (cmd.step && emit_req) || cmd.dump_emit;

    // message store, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.step && wr_en)
            mem[fill_reg[AW-1:0]] <= cur;
        if (cmd.rd)
            rd_data_reg <= mem[rd_ptr_reg[AW-1:0]];
    end

    // packet payload, manufacturer byte, dump length and output payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            b0_reg    <= byte_zero;
            b1_reg    <= byte_one;
            b2_reg    <= byte_two;
            len_reg   <= length;
            cable_reg <= cable;
        end
        if (cmd.step && wr_en && fill_reg == FW'(1))
            maker_byte_reg <= cur;
        if (cmd.step && start_dump)
            dump_len_reg <= fill_reg + FW'(1);
        if (cmd.step && emit_req)
        begin
            out_byte_reg  <= cur;
            out_cable_reg <= cable_reg;
            out_kind_reg  <= emit_kind;
            out_last_reg  <= emit_last;
        end
        else if (cmd.dump_emit)
        begin
            out_byte_reg  <= rd_data_reg;
            out_cable_reg <= cable_reg;
            out_kind_reg  <= KIND_SYSEX;
            out_last_reg  <= stat.dump_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_PASS;
            idx_reg       <= 2'd0;
            fill_reg      <= '0;
            rd_ptr_reg    <= '0;
            out_valid_reg <= 1'b0;
            id_first_reg  <= MAKER_FIRST_RST;
            id_second_reg <= MAKER_SECOND_RST;
        end
        else
        begin
            if (cmd.load)
            begin
                idx_reg <= 2'd0;
                if (fill_reg == '0 && byte_zero == SYSEX_START)
                    mode_reg <= MODE_OPEN;
                else if (fill_reg == '0)
                    mode_reg <= MODE_PASS;
                else
                    mode_reg <= MODE_SYSEX;
            end
            if (cmd.step)
            begin
                idx_reg  <= idx_reg + 2'd1;
                fill_reg <= fill_next;
                if (start_dump)
                    rd_ptr_reg <= '0;
            end
            if (cmd.dump_emit)
                rd_ptr_reg <= rd_ptr_reg + FW'(1);
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (cfg_we && cfg_index == REG_MAKER_FIRST)
                id_first_reg <= cfg_data;
            if (cfg_we && cfg_index == REG_MAKER_SECOND)
                id_second_reg <= cfg_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign data_byte = out_byte_reg;
    assign out_cable = out_cable_reg;
    assign kind      = out_kind_reg;
    assign last      = out_last_reg;

endmodule

// ===== design/msa_ctrl.sv =====
// controller of the midi sysex assembler: walks packet bytes and stored message readout
// drives datapath commands from datapath status
// depends on msa_pkg
module msa_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  msa_pkg::msa_stat_t stat,
    output msa_pkg::msa_cmd_t  cmd
);
    import msa_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_BYTE = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0] state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (!stat.len_zero)
                        state_next = S_BYTE;
                end
            end
            S_BYTE:
            begin
                // hold a byte to be emitted while the output register is occupied
                if (!(stat.emit_req && !stat.out_free))
                begin
                    cmd.step = 1'b1;
                    if (stat.start_dump)
                        state_next = S_RD;
                    else if (stat.end_pkt)
                        state_next = S_IDLE;
                end
            end
            S_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.dump_emit = 1'b1;
                    state_next    = stat.dump_last ? S_IDLE : S_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== design/midi_sysex_assembler.sv =====
// midi sysex assembler top level: controller plus datapath
// a packet is accepted, then its bytes are stepped in turn; plain and realtime bytes
// leave through a one-entry output register, a byte waits there while tx is stalled
// a delivered sysex message leaves the store byte by byte, each read then emitted
// rst_n clears control state, fill count and ids (0x43, 0x7D); store contents stay undefined
module midi_sysex_assembler #(
    parameter int SYSEX_DEPTH = msa_pkg::DEF_SYSEX_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    msa_pkt_if.sink    rx,
    msa_byte_if.source tx,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [6:0] cfg_data
);
    import msa_pkg::*;

    msa_cmd_t  cmd;
    msa_stat_t stat;

    msa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rx.valid),
        .in_ready (rx.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    msa_datapath #(
        .SYSEX_DEPTH (SYSEX_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .byte_zero (rx.byte_zero),
        .byte_one  (rx.byte_one),
        .byte_two  (rx.byte_two),
        .length    (rx.length),
        .cable     (rx.cable),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (tx.valid),
        .out_ready (tx.ready),
        .data_byte (tx.data_byte),
        .out_cable (tx.out_cable),
        .kind      (tx.kind),
        .last      (tx.last)
    );

endmodule

// ===== design/msa_checker.sv =====
// port-level checks for the midi sysex assembler, bound to the top level
// depends on msa_pkg and midi_sysex_assembler
module msa_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       tx_valid,
    input logic       tx_ready,
    input logic [7:0] data_byte,
    input logic [1:0] kind,
    input logic       last
);
    import msa_pkg::*;

    // a stalled output transaction stays offered
    a_tx_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && !tx_ready |=> tx_valid)
        else $error("output transaction dropped while stalled");

    a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid |-> (kind == KIND_PLAIN || kind == KIND_RT || kind == KIND_SYSEX))
        else $error("undefined kind code");

    a_rt_last: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && kind == KIND_RT |-> last)
        else $error("realtime byte without last");

    // every delivered sysex message ends on its end-of-exclusive byte
    a_sysex_end: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && kind == KIND_SYSEX && last |-> data_byte == SYSEX_END)
        else $error("sysex message does not end in F7");

endmodule

bind midi_sysex_assembler msa_checker u_msa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .tx_valid  (tx.valid),
    .tx_ready  (tx.ready),
    .data_byte (tx.data_byte),
    .kind      (tx.kind),
    .last      (tx.last)
);
